// ----- design/c3gf_pkg.sv -----
// Shared constants, types and kernel table for the 3x3 grayscale filter.
// No dependencies; used by the top level only.
`timescale 1ns / 1ps

package c3gf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 12;
  localparam int KSEL_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);

  localparam int COEF_W  = 5;
  localparam int PROD_W  = 14;
  localparam int SUM_W   = 15;
  localparam int BLUR_SHIFT = 4;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;

  localparam logic [KSEL_W-1:0] KSEL_BLUR = 4'd0;
  localparam logic [KSEL_W-1:0] KSEL_LAST = 4'd8;

  localparam logic signed [SUM_W-1:0] SUM_PIX_MAX = 15'sd255;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } flags_t;

  // Row-major taps: blur, Sobel bottom, emboss, identity, Sobel left,
  // outline, Sobel right, sharpen, Sobel top.
  localparam logic signed [COEF_W-1:0] KERNEL_W [0:8][0:8] = '{
    '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
    '{-5'sd1, -5'sd2, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd2,  5'sd1},
    '{-5'sd2, -5'sd1,  5'sd0, -5'sd1,  5'sd1,  5'sd1,  5'sd0,  5'sd1,  5'sd2},
    '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{ 5'sd1,  5'sd0, -5'sd1,  5'sd2,  5'sd0, -5'sd2,  5'sd1,  5'sd0, -5'sd1},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{-5'sd1,  5'sd0,  5'sd1, -5'sd2,  5'sd0,  5'sd2, -5'sd1,  5'sd0,  5'sd1},
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{ 5'sd1,  5'sd2,  5'sd1,  5'sd0,  5'sd0,  5'sd0, -5'sd1, -5'sd2, -5'sd1}
  };

  // Unused kernel codes give an all-zero kernel.
  function automatic logic signed [COEF_W-1:0] kernel_coef(
    input logic [KSEL_W-1:0] sel,
    input logic [3:0]        tap
  );
    logic signed [COEF_W-1:0] coef;
    coef = '0;
    if (sel <= KSEL_LAST) begin
      coef = KERNEL_W[sel][tap];
    end
    return coef;
  endfunction

endpackage

// ----- design/c3gf_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module c3gf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/conv3x3_gray_filter.sv -----
// Streaming 3x3 convolution of a grayscale frame, top level.
// Depends on c3gf_pkg and two c3gf_ram line stores.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (in_valid/in_ready): one pixel per transaction in raster
//    order; pad marks a drain transaction carrying no pixel. After the last
//    pixel of a frame send image_width + 1 pad transactions to flush it.
//  - Output channel (out_valid/out_ready): one filtered pixel per transaction,
//    frame_last on the final pixel of the frame. The first image_width + 1
//    input transactions of a frame produce nothing; result for position p
//    pairs with input p+w+1.
//  - Config channel (cfg_valid/cfg_ready, always ready): index 0 kernel
//    select, 1 image width, 2 image height. Write only while idle. Writing a
//    dimension restarts the frame counters.
//  - Throughput: one transaction per clock while the output FIFO has room. Path: a
//    released result passes the line store read, window/product stage and
//    sum/clamp stage, then enters the output FIFO.
//  - Stall: results queue in an 8-entry output FIFO; input is taken while
//    queued plus in-flight results leave room, so a stalled receiver halts
//    the input only once the FIFO would fill.
//  - Reset: counters, window and FIFO clear; kernel 0 (blur), 2048 x 2048.
//    Line stores are not cleared; unwritten entries only reach border pixels.
module conv3x3_gray_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [c3gf_pkg::PIX_W-1:0]          pixel_in,
  input  logic                                pad,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [c3gf_pkg::PIX_W-1:0]          pixel_out,
  output logic                                frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [c3gf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c3gf_pkg::DIM_W-1:0]          cfg_data
);

  localparam int COL_W = c3gf_pkg::COL_W;
  localparam int ROW_W = c3gf_pkg::ROW_W;
  localparam int DIM_W = c3gf_pkg::DIM_W;
  localparam int PROD_W = c3gf_pkg::PROD_W;
  localparam int SUM_W = c3gf_pkg::SUM_W;
  localparam int FIFO_AW = c3gf_pkg::FIFO_AW;
  localparam int FIFO_CW = c3gf_pkg::FIFO_CW;

  // Map a written dimension onto 1..maxv and return it minus one.
  function automatic logic [DIM_W-1:0] dim_last(
    input logic [DIM_W-1:0] v,
    input logic [DIM_W-1:0] maxv
  );
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (v > maxv) begin
      d = maxv;
    end
    return d - DIM_W'(1);
  endfunction

  // ---------------------------------------------------------------- config
  logic [c3gf_pkg::KSEL_W-1:0] kernel_select;
  logic [COL_W-1:0]            w_last;
  logic [ROW_W-1:0]            h_last;
  logic                        cfg_write;
  logic [DIM_W-1:0]            cfg_dim_last_w;
  logic [DIM_W-1:0]            cfg_dim_last_h;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_dim_last_w = dim_last(cfg_data, DIM_W'(c3gf_pkg::MAX_WIDTH));
  assign cfg_dim_last_h = dim_last(cfg_data, DIM_W'(c3gf_pkg::MAX_HEIGHT));

  // ------------------------------------------------------ position counters
  // in_col addresses the line stores; in_row0 and primed hold off results
  // until the window has seen one full row plus one pixel.
  logic             accept;
  logic [COL_W-1:0] in_col;
  logic             in_row0;
  logic             primed;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  c3gf_pkg::flags_t in_flags;
  c3gf_pkg::pix_t   in_pix;

  assign accept = in_valid && in_ready;
  assign in_pix = pad ? '0 : pixel_in;

  always_comb begin
    in_flags.emit   = primed;
    in_flags.border = (out_row == '0) || (out_row >= h_last) ||
                      (out_col == '0) || (out_col >= w_last);
    in_flags.last   = primed && (out_row >= h_last) && (out_col >= w_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= c3gf_pkg::KSEL_BLUR;
      w_last        <= COL_W'(c3gf_pkg::MAX_WIDTH - 1);
      h_last        <= ROW_W'(c3gf_pkg::MAX_HEIGHT - 1);
      in_col        <= '0;
      in_row0       <= 1'b1;
      primed        <= 1'b0;
      out_col       <= '0;
      out_row       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        c3gf_pkg::REG_KERNEL_SELECT: begin
          kernel_select <= cfg_data[c3gf_pkg::KSEL_W-1:0];
        end
        c3gf_pkg::REG_IMAGE_WIDTH: begin
          w_last  <= cfg_dim_last_w[COL_W-1:0];
          in_col  <= '0;
          in_row0 <= 1'b1;
          primed  <= 1'b0;
          out_col <= '0;
          out_row <= '0;
        end
        c3gf_pkg::REG_IMAGE_HEIGHT: begin
          h_last  <= cfg_dim_last_h[ROW_W-1:0];
          in_col  <= '0;
          in_row0 <= 1'b1;
          primed  <= 1'b0;
          out_col <= '0;
          out_row <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (in_flags.last) begin
        // frame done: restart all positions
        in_col  <= '0;
        in_row0 <= 1'b1;
        primed  <= 1'b0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_col == w_last) begin
          in_col  <= '0;
          in_row0 <= 1'b0;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (!in_row0) begin
          primed <= 1'b1;
        end
        if (primed) begin
          if (out_col >= w_last) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------- stage 1: line store access
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  c3gf_pkg::pix_t   s1_bot;
  c3gf_pkg::flags_t s1_flags;
  logic             s1_fwd;
  c3gf_pkg::pix_t   fwd_above;
  c3gf_pkg::pix_t   fwd_mid;
  c3gf_pkg::pix_t   above_rd;
  c3gf_pkg::pix_t   mid_rd;
  c3gf_pkg::pix_t   s1_top;
  c3gf_pkg::pix_t   s1_mid;

  // The previous transaction writes its column at the same edge this one
  // reads; on the same column take its write data instead of the stale read.
  assign s1_top = s1_fwd ? fwd_above : above_rd;
  assign s1_mid = s1_fwd ? fwd_mid   : mid_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= in_col;
      s1_bot    <= in_pix;
      s1_flags  <= in_flags;
      s1_fwd    <= s1_valid && (s1_col == in_col);
      fwd_above <= s1_mid;
      fwd_mid   <= s1_bot;
    end
  end

  c3gf_ram #(
    .WIDTH (c3gf_pkg::PIX_W),
    .DEPTH (c3gf_pkg::MAX_WIDTH)
  ) u_row_above (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (s1_mid),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (above_rd)
  );

  c3gf_ram #(
    .WIDTH (c3gf_pkg::PIX_W),
    .DEPTH (c3gf_pkg::MAX_WIDTH)
  ) u_row_middle (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (s1_bot),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (mid_rd)
  );

  // ------------------------------------------ window shift, stage 2 products
  c3gf_pkg::pix_t   win [3][3];
  logic             s2_valid;
  c3gf_pkg::flags_t s2_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= s1_top;
      win[1][2] <= s1_mid;
      win[2][2] <= s1_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_flags <= s1_flags;
    end
  end

  logic signed [PROD_W-1:0] prod    [3][3];
  logic signed [PROD_W-1:0] row_sum [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = $signed({1'b0, win[r][c]}) *
                     c3gf_pkg::kernel_coef(kernel_select, 4'(r * 3 + c));
      end
      row_sum[r] = prod[r][0] + prod[r][1] + prod[r][2];
    end
  end

  // ----------------------------------------------- stage 3: sum and clamp
  logic                     s3_valid;
  c3gf_pkg::flags_t         s3_flags;
  logic signed [PROD_W-1:0] s3_row [3];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  scaled;
  c3gf_pkg::pix_t           result_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_flags <= s2_flags;
      for (int r = 0; r < 3; r++) begin
        s3_row[r] <= row_sum[r];
      end
    end
  end

  always_comb begin
    total  = SUM_W'(s3_row[0]) + SUM_W'(s3_row[1]) + SUM_W'(s3_row[2]);
    scaled = (kernel_select == c3gf_pkg::KSEL_BLUR) ? (total >>> c3gf_pkg::BLUR_SHIFT)
                                                    : total;
    if (s3_flags.border || scaled < 0) begin
      result_pix = '0;
    end else if (scaled > c3gf_pkg::SUM_PIX_MAX) begin
      result_pix = c3gf_pkg::PIX_MAX;
    end else begin
      result_pix = scaled[c3gf_pkg::PIX_W-1:0];
    end
  end

  // ------------------------------------------------------- output FIFO
  c3gf_pkg::pix_t     fifo_pix  [c3gf_pkg::FIFO_DEPTH];
  logic               fifo_last [c3gf_pkg::FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] fifo_count;
  logic [FIFO_CW-1:0] credit_used;
  logic               push;
  logic               pop;

  assign push = s3_valid && s3_flags.emit;
  assign pop  = out_valid && out_ready;

  // Reserve room for everything still in flight, so a push never finds
  // the FIFO full.
  assign credit_used = fifo_count + FIFO_CW'(s1_valid) + FIFO_CW'(s2_valid)
                     + FIFO_CW'(s3_valid);
  assign in_ready    = credit_used < FIFO_CW'(c3gf_pkg::FIFO_DEPTH);

  assign out_valid  = fifo_count != '0;
  assign pixel_out  = fifo_pix[rd_ptr];
  assign frame_last = fifo_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_pix[wr_ptr]  <= result_pix;
      fifo_last[wr_ptr] <= s3_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fifo_count <= fifo_count + 1'b1;
      end else if (pop && !push) begin
        fifo_count <= fifo_count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // A result must never arrive at a full FIFO.
  assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count != FIFO_CW'(c3gf_pkg::FIFO_DEPTH)))
    else $error("result pushed into full output FIFO");

  // A same-column transaction behind one in stage 1 always arms forwarding.
  assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid && (s1_col == in_col)) |=> s1_fwd)
    else $error("same-column forwarding not armed");

  // The line store column stays inside the configured row.
  assert property (@(posedge clk) disable iff (rst)
    in_col <= w_last)
    else $error("input column beyond image width");

  // A pushed result is offered at the output on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("pushed result not presented");
`endif

endmodule
